// ----- rtl/bsca_pkg.sv -----
`default_nettype none

package bsca_pkg;

    // Fixed widths of the configuration registers and of the port.
    localparam int DIM_CFG_W = 13;
    localparam int INSET_W   = 4;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INSET  = 2'd2;

    localparam logic [DIM_CFG_W-1:0] WIDTH_RESET  = 13'd256;
    localparam logic [DIM_CFG_W-1:0] HEIGHT_RESET = 13'd256;
    localparam logic [INSET_W-1:0]   INSET_RESET  = 4'd10;
    localparam logic [INSET_W-1:0]   MAX_INSET    = 4'd10;
    localparam int                   MIN_DIM      = 21;

    localparam int NUM_SIDES = 4;
    localparam int NUM_CHAN  = 4;
    localparam int SIDE_W    = 2;
    localparam logic [SIDE_W-1:0] LAST_SIDE = 2'd3;

    // Accumulators, dividends and means.
    localparam int SUM_W      = 20;
    localparam int FRAC_W     = 8;
    localparam int DIVIDEND_W = SUM_W + FRAC_W;
    localparam int MEAN_W     = 16;
    localparam logic [MEAN_W-1:0] MEAN_MAX = 16'd65280;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

    typedef struct packed {
        logic [7:0] pix_red;
        logic [7:0] pix_green;
        logic [7:0] pix_blue;
        logic [7:0] pix_alpha;
    } pix_t;

    typedef struct packed {
        logic [SIDE_W-1:0] side;
        logic [MEAN_W-1:0] mean_red;
        logic [MEAN_W-1:0] mean_green;
        logic [MEAN_W-1:0] mean_blue;
        logic [MEAN_W-1:0] mean_alpha;
        logic              last_side;
    } res_t;

    // Microprogram steps.
    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_PIXEL = 3'd0;
    localparam step_t STEP_LOAD  = 3'd1;
    localparam step_t STEP_DIV   = 3'd2;
    localparam step_t STEP_EMIT  = 3'd3;
    localparam step_t STEP_NEXT  = 3'd4;

    typedef enum logic [2:0] {
        COND_ALWAYS    = 3'd0,
        COND_WIN_END   = 3'd1,
        COND_DIV_DONE  = 3'd2,
        COND_OUT_TAKEN = 3'd3,
        COND_LAST_SIDE = 3'd4
    } cond_t;

    typedef struct packed {
        logic  take_pixel;
        logic  load_side;
        logic  div_step;
        logic  emit;
        logic  advance;
        cond_t cond;
        step_t target_true;
        step_t target_false;
    } uword_t;

    typedef struct packed {
        logic win_end;
        logic out_taken;
        logic last_side;
    } seq_status_t;

    // The control store. Each step names the condition that picks its successor.
    function automatic uword_t ucode(input step_t step);
        uword_t w;
        w = '{take_pixel: 1'b0, load_side: 1'b0, div_step: 1'b0, emit: 1'b0,
              advance: 1'b0, cond: COND_ALWAYS, target_true: STEP_PIXEL,
              target_false: STEP_PIXEL};
        case (step)
            STEP_PIXEL:
            begin
                w.take_pixel   = 1'b1;
                w.cond         = COND_WIN_END;
                w.target_true  = STEP_LOAD;
                w.target_false = STEP_PIXEL;
            end
            STEP_LOAD:
            begin
                w.load_side    = 1'b1;
                w.cond         = COND_ALWAYS;
                w.target_true  = STEP_DIV;
                w.target_false = STEP_DIV;
            end
            STEP_DIV:
            begin
                w.div_step     = 1'b1;
                w.cond         = COND_DIV_DONE;
                w.target_true  = STEP_EMIT;
                w.target_false = STEP_DIV;
            end
            STEP_EMIT:
            begin
                w.emit         = 1'b1;
                w.cond         = COND_OUT_TAKEN;
                w.target_true  = STEP_NEXT;
                w.target_false = STEP_EMIT;
            end
            STEP_NEXT:
            begin
                w.advance      = 1'b1;
                w.cond         = COND_LAST_SIDE;
                w.target_true  = STEP_PIXEL;
                w.target_false = STEP_LOAD;
            end
            default:
            begin
                w.cond = COND_ALWAYS;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bsca_seq.sv -----
`default_nettype none

module bsca_seq
    import bsca_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire seq_status_t status,
    output uword_t           ctl
);

    step_t                  step_reg;
    step_t                  step_next;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic [DIV_CNT_W-1:0]   cnt_next;
    logic                   div_done;
    logic                   cond_true;

    assign ctl      = ucode(step_reg);
    assign div_done = (cnt_reg == '0);

    always_comb
    begin
        case (ctl.cond)
            COND_ALWAYS:    cond_true = 1'b1;
            COND_WIN_END:   cond_true = status.win_end;
            COND_DIV_DONE:  cond_true = div_done;
            COND_OUT_TAKEN: cond_true = status.out_taken;
            COND_LAST_SIDE: cond_true = status.last_side;
            default:        cond_true = 1'b1;
        endcase
        step_next = cond_true ? ctl.target_true : ctl.target_false;
    end

    // The loop counter holds the number of divide iterations still to run after the current one.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctl.load_side)
        begin
            cnt_next = DIV_CNT_W'(DIVIDEND_W - 1);
        end
        else if (ctl.div_step && !div_done)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_PIXEL;
            cnt_reg  <= '0;
        end
        else
        begin
            step_reg <= step_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/bsca_accum.sv -----
`default_nettype none

module bsca_accum
    import bsca_pkg::*;
#(
    parameter int CW = 12,
    parameter int DW = 13
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              accept,
    input  wire pix_t                              pix,
    input  wire logic [DW-1:0]                     width_eff,
    input  wire logic [DW-1:0]                     height_eff,
    input  wire logic [INSET_W-1:0]                inset_eff,
    input  wire logic                              advance,
    output logic                                   win_end,
    output logic [SIDE_W-1:0]                      side,
    output logic [NUM_CHAN-1:0][SUM_W-1:0]         bank0
);

    logic [CW-1:0]     col_reg;
    logic [CW-1:0]     row_reg;
    logic [SIDE_W-1:0] side_reg;
    logic [SUM_W-1:0]  sums_reg [NUM_SIDES][NUM_CHAN];
    logic [DW-1:0]     right_col;
    logic [DW-1:0]     rear_row;
    logic [NUM_SIDES-1:0] hit;
    logic [7:0]        ch [NUM_CHAN];
    logic              row_end;

    assign ch[0] = pix.pix_red;
    assign ch[1] = pix.pix_green;
    assign ch[2] = pix.pix_blue;
    assign ch[3] = pix.pix_alpha;

    // A zero inset would put the right column and rear row outside the window.
    always_comb
    begin
        if (inset_eff == '0)
        begin
            right_col = width_eff - 1'b1;
            rear_row  = height_eff - 1'b1;
        end
        else
        begin
            right_col = width_eff - DW'(inset_eff);
            rear_row  = height_eff - DW'(inset_eff);
        end
        hit[0]  = (row_reg == CW'(inset_eff));
        hit[1]  = (DW'(col_reg) == right_col);
        hit[2]  = (DW'(row_reg) == rear_row);
        hit[3]  = (col_reg == CW'(inset_eff));
        row_end = (DW'(col_reg) >= width_eff - 1'b1);
        win_end = accept && row_end && (DW'(row_reg) >= height_eff - 1'b1);
    end

    assign side = side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            side_reg <= '0;
        end
        else if (accept)
        begin
            if (!row_end)
            begin
                col_reg <= col_reg + 1'b1;
            end
            else
            begin
                col_reg <= '0;
                row_reg <= win_end ? '0 : row_reg + 1'b1;
            end
        end
        else if (advance)
        begin
            side_reg <= side_reg + 1'b1;
        end
    end

    // Advancing shifts the side banks toward bank 0 and fills with zeros, so
    // four advances leave every sum cleared for the next window.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SIDES; s++)
            begin
                for (int c = 0; c < NUM_CHAN; c++)
                begin
                    sums_reg[s][c] <= '0;
                end
            end
        end
        else if (advance)
        begin
            for (int s = 0; s < NUM_SIDES - 1; s++)
            begin
                for (int c = 0; c < NUM_CHAN; c++)
                begin
                    sums_reg[s][c] <= sums_reg[s+1][c];
                end
            end
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                sums_reg[NUM_SIDES-1][c] <= '0;
            end
        end
        else if (accept)
        begin
            for (int s = 0; s < NUM_SIDES; s++)
            begin
                for (int c = 0; c < NUM_CHAN; c++)
                begin
                    if (hit[s])
                    begin
                        sums_reg[s][c] <= sums_reg[s][c] + SUM_W'(ch[c]);
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            bank0[c] = sums_reg[0][c];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/bsca_div_lane.sv -----
`default_nettype none

module bsca_div_lane
    import bsca_pkg::*;
#(
    parameter int DW = 13
)
(
    input  wire logic              clk,
    input  wire logic              load,
    input  wire logic              step,
    input  wire logic [SUM_W-1:0]  sum,
    input  wire logic [DW-1:0]     divisor,
    output logic [MEAN_W-1:0]      mean
);

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DW-1:0]         rem_reg;
    logic [DW:0]           trial;
    logic [DW:0]           diff;
    logic                  fits;

    // Restoring division, one quotient bit per step, MSB first.
    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = (trial >= {1'b0, divisor});

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quo_reg <= {sum, FRAC_W'(0)};
            rem_reg <= '0;
        end
        else if (step)
        begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
            rem_reg <= fits ? diff[DW-1:0] : trial[DW-1:0];
        end
    end

    assign mean = (quo_reg > DIVIDEND_W'(MEAN_MAX)) ? MEAN_MAX : quo_reg[MEAN_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/border_strip_color_average.sv -----
`default_nettype none

// Border strip color average. Pixels of one window arrive in raster order on
// the pix channel, one beat per clock while the block is accumulating. Four
// sampling lines are summed per channel: the row at the inset (front), the
// column at width minus inset (right), the row at height minus inset (rear)
// and the column at the inset (left); a zero inset puts the right and rear
// lines on the last column and row. After the last pixel of the window the
// block stops taking pixels and produces four result beats, front, right,
// rear, left, each carrying the truncated per-channel mean in unsigned Q8.8
// (saturated at 255.0); last_side marks the fourth. Each side takes a load
// step, the divide steps of the bit-serial divider (four channel lanes run
// side by side), the result beat, which waits while res_stall is high, and
// an advance step; pixel intake stays closed until the last side advances.
// Sizes saturate into 21..MAX_DIM and the inset to 10. The user must write
// registers only while idle, unenforced by the block; writes act at once.
module border_strip_color_average
    import bsca_pkg::*;
#(
    parameter int MAX_DIM = 4096
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    input  wire logic                  pix_valid,
    output logic                       pix_stall,
    input  wire pix_t                  pix,
    output logic                       res_valid,
    input  wire logic                  res_stall,
    output res_t                       res
);

    // Counters need to reach MAX_DIM - 1; effective sizes must hold MAX_DIM.
    localparam int CW = $clog2(MAX_DIM);
    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int EW = (DW > DIM_CFG_W) ? DW : DIM_CFG_W;

    logic [DIM_CFG_W-1:0] cfg_width_reg;
    logic [DIM_CFG_W-1:0] cfg_height_reg;
    logic [INSET_W-1:0]   cfg_inset_reg;

    logic [DW-1:0]        width_eff;
    logic [DW-1:0]        height_eff;
    logic [INSET_W-1:0]   inset_eff;
    logic [DW-1:0]        div_n_reg;

    uword_t               ctl;
    seq_status_t          status;
    logic                 accept;
    logic                 win_end;
    logic [SIDE_W-1:0]    side;
    logic [NUM_CHAN-1:0][SUM_W-1:0]  bank0;
    logic [NUM_CHAN-1:0][MEAN_W-1:0] means;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width_reg  <= WIDTH_RESET;
            cfg_height_reg <= HEIGHT_RESET;
            cfg_inset_reg  <= INSET_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH:  cfg_width_reg  <= cfg_data[DIM_CFG_W-1:0];
                REG_HEIGHT: cfg_height_reg <= cfg_data[DIM_CFG_W-1:0];
                REG_INSET:  cfg_inset_reg  <= cfg_data[INSET_W-1:0];
                default:    ;
            endcase
        end
    end

    // Saturate the window size and the inset into their legal ranges.
    always_comb
    begin
        if (EW'(cfg_width_reg) < EW'(MIN_DIM))
            width_eff = DW'(MIN_DIM);
        else if (EW'(cfg_width_reg) > EW'(MAX_DIM))
            width_eff = DW'(MAX_DIM);
        else
            width_eff = DW'(cfg_width_reg);

        if (EW'(cfg_height_reg) < EW'(MIN_DIM))
            height_eff = DW'(MIN_DIM);
        else if (EW'(cfg_height_reg) > EW'(MAX_DIM))
            height_eff = DW'(MAX_DIM);
        else
            height_eff = DW'(cfg_height_reg);

        inset_eff = (cfg_inset_reg > MAX_INSET) ? MAX_INSET : cfg_inset_reg;
    end

    // The microprogram sequencer owns all control.
    assign pix_stall = !ctl.take_pixel;
    assign accept    = pix_valid && ctl.take_pixel;
    assign res_valid = ctl.emit;

    assign status.win_end   = win_end;
    assign status.out_taken = res_valid && !res_stall;
    assign status.last_side = (side == LAST_SIDE);

    bsca_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctl    (ctl)
    );

    bsca_accum #(
        .CW (CW),
        .DW (DW)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .pix        (pix),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .inset_eff  (inset_eff),
        .advance    (ctl.advance),
        .win_end    (win_end),
        .side       (side),
        .bank0      (bank0)
    );

    // Rows divide by the width, columns by the height.
    always_ff @(posedge clk)
    begin
        if (ctl.load_side)
        begin
            div_n_reg <= side[0] ? height_eff : width_eff;
        end
    end

    for (genvar c = 0; c < NUM_CHAN; c++)
    begin : g_lane
        bsca_div_lane #(
            .DW (DW)
        ) u_lane (
            .clk     (clk),
            .load    (ctl.load_side),
            .step    (ctl.div_step),
            .sum     (bank0[c]),
            .divisor (div_n_reg),
            .mean    (means[c])
        );
    end

    // The quotient registers hold still while the result beat waits.
    assign res.side       = side;
    assign res.mean_red   = means[0];
    assign res.mean_green = means[1];
    assign res.mean_blue  = means[2];
    assign res.mean_alpha = means[3];
    assign res.last_side  = (side == LAST_SIDE);

endmodule

`default_nettype wire

// ----- rtl/bsca_checker.sv -----
`default_nettype none

module bsca_checker
    import bsca_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic pix_valid,
    input wire logic pix_stall,
    input wire logic res_valid,
    input wire logic res_stall,
    input wire res_t res
);

    // A waiting result beat stays and holds its payload.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result beat changed while stalled");

    // Pixels are never taken while results are being delivered.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> pix_stall)
        else $error("pixel intake open during result delivery");

    // Only the left side closes a window.
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.last_side == (res.side == LAST_SIDE)))
        else $error("last_side does not match side");

    // Until the fourth side has gone out, the block keeps pixel intake closed.
    a_busy_to_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_stall && !res.last_side |=> pix_stall)
        else $error("pixel intake reopened before the last side");

    // Means saturate at 255.0.
    a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.mean_red <= MEAN_MAX) && (res.mean_green <= MEAN_MAX)
                   && (res.mean_blue <= MEAN_MAX) && (res.mean_alpha <= MEAN_MAX))
        else $error("mean above saturation limit");

endmodule

bind border_strip_color_average bsca_checker u_bsca_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

`default_nettype wire

// ----- test/border_strip_color_average_tb.sv -----
`timescale 1ns / 100ps

module border_strip_color_average_tb;

    import bsca_pkg::*;

    localparam int MAX_DIM = 4096;

    // Cycles to let pass before a register write once nothing is expected.
    // The block still takes an advance step after the last beat of a window.
    localparam int SETTLE_CYCLES = 10;
    // Quiet cycles at the very end, enough for a window to produce its four
    // beats, so any stray beat shows up in this time.
    localparam int TAIL_CYCLES = 300;
    // The run sends about 193k pixels. The slowest legal run idles before
    // each pixel and stalls each result beat of every window. CYCLE_LIMIT
    // covers that several times over.
    localparam int CYCLE_LIMIT = 10_000_000;

    // Side codes in the order the block reports them.
    typedef enum logic [SIDE_W-1:0]
    {
        SIDE_FRONT,
        SIDE_RIGHT,
        SIDE_REAR,
        SIDE_LEFT
    } side_e;

    // Pixel content used to fill a window.
    typedef enum
    {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_FULL
    } fill_e;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 pix_valid;
    logic                 pix_stall;
    pix_t                 pix;
    logic                 res_valid;
    logic                 res_stall;
    res_t                 res;

    // Our own copy of the block's registers and accumulation state.
    logic [DIM_CFG_W-1:0] cfg_width  = WIDTH_RESET;
    logic [DIM_CFG_W-1:0] cfg_height = HEIGHT_RESET;
    logic [INSET_W-1:0]   cfg_inset  = INSET_RESET;
    logic [11:0]          col_idx    = '0;
    logic [11:0]          row_idx    = '0;
    logic [SUM_W-1:0]     strip_sum [NUM_SIDES][NUM_CHAN] = '{default: '0};

    // Side means that the block still owes us, oldest first.
    res_t side_means_due [$];

    // When set, neither side idles or stalls any more.
    bit steady = 1'b0;

    int unsigned fault_count    = 0;
    int unsigned sides_checked  = 0;
    int unsigned pixels_sent    = 0;
    int unsigned windows_closed = 0;
    int unsigned cycle_count    = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    border_strip_color_average #(
        .MAX_DIM(MAX_DIM)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .pix_valid(pix_valid),
        .pix_stall(pix_stall),
        .pix      (pix),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res      (res)
    );

    // Window sizes are forced into MIN_DIM..MAX_DIM before they are used.
    function automatic int unsigned saturate_size(input logic [DIM_CFG_W-1:0] raw);
        if (raw < MIN_DIM)
            return MIN_DIM;
        if (raw > MAX_DIM)
            return MAX_DIM;
        return raw;
    endfunction

    // Adds one accepted pixel to the strips it lies on and moves the raster
    // position on. At the end of a window the four side means are queued
    // and the sums cleared. Returns 1 when the pixel closed a window.
    function automatic bit accumulate_pixel(input pix_t value);
        int unsigned       w;
        int unsigned       h;
        int unsigned       inset;
        int unsigned       right_col;
        int unsigned       rear_row;
        int unsigned       n;
        int unsigned       quot;
        logic [7:0]        chan [NUM_CHAN];
        logic [MEAN_W-1:0] mean [NUM_CHAN];
        res_t              beat;

        w         = saturate_size(cfg_width);
        h         = saturate_size(cfg_height);
        inset     = (cfg_inset > MAX_INSET) ? MAX_INSET : cfg_inset;
        // With no inset the far strips would fall just outside the window,
        // so they sit on the last column and the last row instead.
        right_col = (inset == 0) ? w - 1 : w - inset;
        rear_row  = (inset == 0) ? h - 1 : h - inset;

        chan[0] = value.pix_red;
        chan[1] = value.pix_green;
        chan[2] = value.pix_blue;
        chan[3] = value.pix_alpha;

        for (int c = 0; c < NUM_CHAN; c++)
        begin
            if (row_idx == inset)
                strip_sum[SIDE_FRONT][c] += chan[c];
            if (col_idx == right_col)
                strip_sum[SIDE_RIGHT][c] += chan[c];
            if (row_idx == rear_row)
                strip_sum[SIDE_REAR][c] += chan[c];
            if (col_idx == inset)
                strip_sum[SIDE_LEFT][c] += chan[c];
        end

        // Ends are tested with >= so that a size shrunk mid-window still
        // closes the row or the window on the next pixel.
        if (col_idx < w - 1)
        begin
            col_idx++;
            return 1'b0;
        end
        col_idx = '0;
        if (row_idx < h - 1)
        begin
            row_idx++;
            return 1'b0;
        end
        row_idx = '0;

        for (int s = 0; s < NUM_SIDES; s++)
        begin
            n = (s == SIDE_FRONT || s == SIDE_REAR) ? w : h;
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                // Truncated Q8.8 mean. It can only pass 255.0 after a size
                // was reduced mid-window, and then it saturates.
                quot = {strip_sum[s][c], 8'h00} / n;
                if (quot > MEAN_MAX)
                    quot = MEAN_MAX;
                mean[c] = MEAN_W'(quot);
            end
            beat.side       = SIDE_W'(s);
            beat.mean_red   = mean[0];
            beat.mean_green = mean[1];
            beat.mean_blue  = mean[2];
            beat.mean_alpha = mean[3];
            beat.last_side  = (beat.side == LAST_SIDE);
            side_means_due.insert(side_means_due.size(), beat);
        end
        foreach (strip_sum[s, c])
            strip_sum[s][c] = '0;
        windows_closed++;
        return 1'b1;
    endfunction

    // Checks one result beat against the oldest side mean still owed.
    function automatic void compare_side_means(input res_t got);
        res_t want;

        if (side_means_due.size() == 0)
        begin
            fault_count++;
            if (fault_count <= 10)
                $display("Unexpected result beat: side=%0d rgba=%h %h %h %h last=%b",
                         got.side, got.mean_red, got.mean_green, got.mean_blue,
                         got.mean_alpha, got.last_side);
            return;
        end
        want = side_means_due.pop_front();
        sides_checked++;
        if (got.side !== want.side || got.mean_red !== want.mean_red ||
            got.mean_green !== want.mean_green || got.mean_blue !== want.mean_blue ||
            got.mean_alpha !== want.mean_alpha || got.last_side !== want.last_side)
        begin
            fault_count++;
            if (fault_count <= 10)
                $display("Side mean mismatch: expected side=%0d rgba=%h %h %h %h last=%b,",
                         want.side, want.mean_red, want.mean_green, want.mean_blue,
                         want.mean_alpha, want.last_side,
                         " got side=%0d rgba=%h %h %h %h last=%b",
                         got.side, got.mean_red, got.mean_green, got.mean_blue,
                         got.mean_alpha, got.last_side);
        end
    endfunction

    function automatic pix_t make_pixel(input fill_e fill);
        case (fill)
            FILL_ZERO: return '0;
            FILL_FULL: return '1;
            default:   return pix_t'($urandom());
        endcase
    endfunction

    // Result side. Every rising edge at which a beat is taken is checked,
    // then the stall for the next cycle is chosen. Stalls start at random
    // moments, so they land on every step of the side sequence.
    initial
    begin
        int unsigned hold;

        hold = 0;
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
                compare_side_means(res);
            if (hold != 0)
                hold--;
            else if (!steady && $urandom_range(0, 5) == 0)
                hold = $urandom_range(1, 13);
            res_stall <= (hold != 0);
        end
    end

    // A run that hangs is ended here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("border_strip_color_average_tb NOT OK");
            $finish;
        end
    end

    // Writes one register. The enable drops in the cycle after it rises and
    // the task waits on the clock once more, so back-to-back writes never
    // lower and raise the enable in the same time step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_WIDTH:  cfg_width  = DIM_CFG_W'(value);
            REG_HEIGHT: cfg_height = DIM_CFG_W'(value);
            REG_INSET:  cfg_inset  = INSET_W'(value);
            default:    ;
        endcase
        @(posedge clk);
    endtask

    task automatic configure(input int unsigned width, input int unsigned height,
                             input int unsigned inset);
        write_reg(REG_WIDTH, width);
        write_reg(REG_HEIGHT, height);
        write_reg(REG_INSET, inset);
    endtask

    // Sends one pixel beat. The sender sometimes idles first; once valid
    // is up the payload is held until the block takes it.
    task automatic send_pixel(input pix_t value, output bit closed);
        if (!steady && $urandom_range(0, 7) == 0)
        begin
            pix_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix       <= value;
        @(posedge clk);
        while (pix_stall)
            @(posedge clk);
        closed = accumulate_pixel(value);
        pixels_sent++;
    endtask

    // Sends pixels until the current window closes.
    task automatic send_window(input fill_e fill);
        bit closed;

        closed = 1'b0;
        while (!closed)
            send_pixel(make_pixel(fill), closed);
    endtask

    // Lowers valid, waits until every owed beat has come and then lets
    // the block finish its last side before anything else happens.
    task automatic drain(input int unsigned settle);
        pix_valid <= 1'b0;
        while (side_means_due.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Smallest window with a zero inset, where the right and rear strips
    // fall on the last column and row. Full and empty pixels give the
    // largest and smallest means; these windows follow each other without a pause.
    task automatic test_extreme_pixels();
        configure(MIN_DIM, MIN_DIM, 0);
        send_window(FILL_FULL);
        send_window(FILL_ZERO);
        send_window(FILL_RANDOM);
        drain(SETTLE_CYCLES);
        write_reg(REG_INSET, MAX_INSET);
        send_window(FILL_RANDOM);
        drain(SETTLE_CYCLES);
    endtask

    // Register values outside the legal ranges. The widest window of full
    // pixels also fills the strip sums almost to the top of their width.
    task automatic test_size_saturation();
        configure(0, MIN_DIM - 1, 15);
        send_window(FILL_RANDOM);
        drain(SETTLE_CYCLES);
        configure(8191, 0, 0);
        send_window(FILL_FULL);
        drain(SETTLE_CYCLES);
        configure(0, 8191, 10);
        send_window(FILL_RANDOM);
        drain(SETTLE_CYCLES);
    endtask

    // Writes that land in the middle of a window take effect at once and
    // keep the counters and the sums.
    task automatic test_mid_window_writes();
        bit closed;

        configure(100, 30, 1);
        // Three full rows put a 100 pixel front strip into the sums.
        repeat (300) send_pixel(make_pixel(FILL_FULL), closed);
        drain(SETTLE_CYCLES);
        // Dividing that strip by 21 overflows the mean, which saturates.
        write_reg(REG_WIDTH, MIN_DIM);
        repeat (5 * MIN_DIM) send_pixel(make_pixel(FILL_RANDOM), closed);
        drain(SETTLE_CYCLES);
        // The raster is already past the new last row, so the window closes
        // at the end of the row in progress.
        write_reg(REG_HEIGHT, 5);
        send_window(FILL_RANDOM);
        drain(SETTLE_CYCLES);
    endtask

    function automatic int unsigned pick_size(input int unsigned top);
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, MIN_DIM - 1);
        return $urandom_range(MIN_DIM, top);
    endfunction

    // Random small windows with random content. Most get a fresh setting
    // after a pause; the rest follow the previous window directly.
    task automatic test_random_windows(input int unsigned count);
        repeat (count)
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                drain(SETTLE_CYCLES);
                configure(pick_size(40), pick_size(32), $urandom_range(0, 15));
            end
            send_window(FILL_RANDOM);
        end
        drain(SETTLE_CYCLES);
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_WIDTH;
        cfg_data  <= '0;
        pix_valid <= 1'b0;
        pix       <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extreme_pixels();
        test_size_saturation();
        test_mid_window_writes();
        test_random_windows(12);
        // The last windows run with both sides at full rate.
        steady = 1'b1;
        test_random_windows(3);

        drain(TAIL_CYCLES);
        if (side_means_due.size() != 0)
        begin
            fault_count += side_means_due.size();
            $display("%0d side results never arrived", side_means_due.size());
        end

        $display("Covered %0d windows from %0d pixels: empty, full and random content,",
                 windows_closed, pixels_sent);
        $display("zero and saturated insets and sizes, writes inside a window; %0d beats checked.",
                 sides_checked);
        if (fault_count == 0)
            $display("border_strip_color_average_tb OK");
        else
            $display("border_strip_color_average_tb NOT OK");
        $finish;
    end

endmodule
